### rtl/smm_pkg.sv
// Shared types and constants for the square matrix multiply core.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smm_pkg;

	localparam int IDX_W   = 2;
	localparam int VAL_W   = 32;
	localparam int SIZE_W  = 3;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int ACC_W   = PROD_W + 3;

	localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_A_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B_SIZE = 1'd1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;

	localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic             first;
		logic             lastk;
		logic             lastel;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} smm_tag_t;

	typedef struct packed {
		logic             issue;
		smm_tag_t         tag;
		logic [IDX_W-1:0] k;
	} smm_cmd_t;

	typedef struct packed {
		logic advance;
	} smm_stat_t;

endpackage
`default_nettype wire

### rtl/smm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for both matrix stores.
`timescale 1ns / 1ps
`default_nettype none
module smm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/smm_ctrl.sv
// Controller: size registers, load decode and the i/j/k sequencer of a compute.
// Depends on smm_pkg; drives the datapath through smm_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module smm_ctrl #(
	parameter int MAX_DIM = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [smm_pkg::MODE_W-1:0]    mode,
	input  wire logic [smm_pkg::IDX_W-1:0]     row,
	input  wire logic [smm_pkg::IDX_W-1:0]     col,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [smm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [smm_pkg::SIZE_W-1:0]    cfg_data,
	output logic                               we_a,
	output logic                               we_b,
	output smm_pkg::smm_cmd_t                  cmd,
	input  wire smm_pkg::smm_stat_t            stat
);
	import smm_pkg::*;

	localparam int DIM_CAP = (MAX_DIM < 4) ? MAX_DIM : 4;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	logic [SIZE_W-1:0] a_size_q;
	logic [SIZE_W-1:0] b_size_q;
	logic [IDX_W-1:0]  last_row_q;
	logic [IDX_W-1:0]  last_col_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  k_q;
	logic [SIZE_W-1:0] rows;
	logic [SIZE_W-1:0] cols;
	logic              accept;
	logic              in_range;
	logic              start;

	assign rows = (a_size_q > SIZE_W'(DIM_CAP)) ? SIZE_W'(DIM_CAP) : a_size_q;
	assign cols = (b_size_q > SIZE_W'(DIM_CAP)) ? SIZE_W'(DIM_CAP) : b_size_q;

	assign item_ready = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign accept     = item_valid && item_ready;
	assign in_range   = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
	assign we_a       = accept && (mode == MODE_LOAD_A) && in_range;
	assign we_b       = accept && (mode == MODE_LOAD_B) && in_range;
	assign start      = accept && (mode == MODE_COMPUTE) && (rows != '0) && (cols != '0);

	always_comb begin
		cmd            = '0;
		cmd.issue      = (state_q == ST_RUN) && stat.advance;
		cmd.tag.first  = (k_q == '0);
		cmd.tag.lastk  = (k_q == last_row_q);
		cmd.tag.lastel = (i_q == last_row_q) && (j_q == last_col_q);
		cmd.tag.i      = i_q;
		cmd.tag.j      = j_q;
		cmd.k          = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_size_q <= SIZE_RESET;
			b_size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_A_SIZE: a_size_q <= cfg_data;
				CFG_B_SIZE: b_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			last_row_q <= '0;
			last_col_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q    <= ST_RUN;
						i_q        <= '0;
						j_q        <= '0;
						k_q        <= '0;
						last_row_q <= IDX_W'(rows - 3'd1);
						last_col_q <= IDX_W'(cols - 3'd1);
					end
				end
				ST_RUN: begin
					if (cmd.issue) begin
						if (k_q == last_row_q) begin
							k_q <= '0;
							if (j_q == last_col_q) begin
								j_q <= '0;
								if (i_q == last_row_q) begin
									state_q <= ST_IDLE;
								end else begin
									i_q <= i_q + 1'b1;
								end
							end else begin
								j_q <= j_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_RUN) && (i_q == '0) && (j_q == '0) && (k_q == '0))
		else $error("Compute start did not enter the run state at the origin.");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && cmd.tag.lastel && cmd.tag.lastk |=> (state_q == ST_IDLE))
		else $error("Sequencer kept running after the final product.");

	a_counters_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |->
			(i_q <= last_row_q) && (j_q <= last_col_q) && (k_q <= last_row_q))
		else $error("Sequencer index ran past the matrix size.");
`endif

endmodule
`default_nettype wire

### rtl/smm_dp.sv
// Datapath: matrix stores, multiply-accumulate pipeline, truncating shift,
// saturation and the result register. Depends on smm_pkg and smm_ram.
`timescale 1ns / 1ps
`default_nettype none
module smm_dp #(
	parameter int MAX_DIM   = 4,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      we_a,
	input  wire logic                      we_b,
	input  wire logic [smm_pkg::IDX_W-1:0] row,
	input  wire logic [smm_pkg::IDX_W-1:0] col,
	input  wire logic [smm_pkg::VAL_W-1:0] value,
	input  wire smm_pkg::smm_cmd_t         cmd,
	output smm_pkg::smm_stat_t             stat,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output logic [smm_pkg::IDX_W-1:0]      out_row,
	output logic [smm_pkg::IDX_W-1:0]      out_col,
	output logic [smm_pkg::VAL_W-1:0]      product,
	output logic                           saturated,
	output logic                           last
);
	import smm_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                     advance;
	logic [ADDR_W-1:0]        waddr;
	logic [ADDR_W-1:0]        raddr_a;
	logic [ADDR_W-1:0]        raddr_b;
	logic [VAL_W-1:0]         a_s1;
	logic [VAL_W-1:0]         b_s1;
	logic                     v_s1;
	smm_tag_t                 tag_s1;
	logic                     v_s2;
	smm_tag_t                 tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s3;
	smm_tag_t                 tag_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  shifted;
	logic                     fits;
	logic                     out_valid_q;

	assign advance      = !out_valid_q || result_ready;
	assign stat.advance = advance;
	assign result_valid = out_valid_q;

	assign waddr   = ADDR_W'(int'(row) * MAX_DIM + int'(col));
	assign raddr_a = ADDR_W'(int'(cmd.tag.i) * MAX_DIM + int'(cmd.k));
	assign raddr_b = ADDR_W'(int'(cmd.k) * MAX_DIM + int'(cmd.tag.j));

	smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_store (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(value),
		.re   (advance),
		.raddr(raddr_a),
		.rdata(a_s1)
	);

	smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_store (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(value),
		.re   (advance),
		.raddr(raddr_b),
		.rdata(b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2 && tag_s2.lastk;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tag_s1  <= cmd.tag;
			tag_s2  <= tag_s1;
			prod_s2 <= $signed(a_s1) * $signed(b_s1);
			if (v_s2) begin
				tag_s3 <= tag_s2;
				acc_q  <= tag_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign shifted = acc_q >>> FRAC_BITS;
	assign fits    = (&shifted[ACC_W-1:VAL_W-1]) || !(|shifted[ACC_W-1:VAL_W-1]);

	always_ff @(posedge clk) begin
		if (advance && v_s3) begin
			out_row   <= tag_s3.i;
			out_col   <= tag_s3.j;
			last      <= tag_s3.lastel;
			saturated <= !fits;
			product   <= fits ? shifted[VAL_W-1:0] : (acc_q[ACC_W-1] ? Q_MIN : Q_MAX);
		end
	end

`ifndef SYNTHESIS
	a_result_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s3))
		else $error("Result appeared without a finished sum.");

	a_sat_clamps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && saturated |-> (product == Q_MAX) || (product == Q_MIN))
		else $error("Saturated result is not a range limit.");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(acc_q) && $stable(v_s3) && $stable(v_s2))
		else $error("Pipeline moved while the result register was blocked.");
`endif

endmodule
`default_nettype wire

### rtl/square_matrix_multiply_core.sv
// A compute runs one product per cycle through a shared multiply-accumulate while the
// result register is not blocked. The next item is taken once the last product issues.
// Throughput is set by the single multiplier and the one read port of each store.
// Reset clears control state and sets both sizes to 4; the matrix stores are not cleared.
// Top level: joins smm_ctrl and smm_dp; depends on smm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module square_matrix_multiply_core #(
	parameter int MAX_DIM   = 4,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [smm_pkg::MODE_W-1:0]    mode,
	input  wire logic [smm_pkg::IDX_W-1:0]     row,
	input  wire logic [smm_pkg::IDX_W-1:0]     col,
	input  wire logic [smm_pkg::VAL_W-1:0]     value,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [smm_pkg::IDX_W-1:0]          out_row,
	output logic [smm_pkg::IDX_W-1:0]          out_col,
	output logic [smm_pkg::VAL_W-1:0]          product,
	output logic                               saturated,
	output logic                               last,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [smm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [smm_pkg::SIZE_W-1:0]    cfg_data
);
	import smm_pkg::*;

	logic      we_a;
	logic      we_b;
	smm_cmd_t  cmd;
	smm_stat_t stat;

	smm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode      (mode),
		.row       (row),
		.col       (col),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.we_a      (we_a),
		.we_b      (we_b),
		.cmd       (cmd),
		.stat      (stat)
	);

	smm_dp #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.we_a        (we_a),
		.we_b        (we_b),
		.row         (row),
		.col         (col),
		.value       (value),
		.cmd         (cmd),
		.stat        (stat),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_row     (out_row),
		.out_col     (out_col),
		.product     (product),
		.saturated   (saturated),
		.last        (last)
	);

endmodule
`default_nettype wire
